FILE: hw/rtl/fma_pkg.sv
// Shared types, constants and helper functions for the factor marginal
// accumulate unit. No dependencies.
package fma_pkg;

  localparam int MAX_VARS   = 4;
  localparam int MAX_CARD   = 16;
  localparam int VALUE_BITS = 16;
  localparam int SUM_W      = 32;
  localparam int DIG_W      = $clog2(MAX_CARD);
  localparam int BIN_AW     = $clog2(MAX_CARD);
  localparam int CARD_W     = $clog2(MAX_CARD + 1);
  localparam int VCNT_W     = 3;
  localparam int POS_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_A        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_B        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_C        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_D        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_POSITION = 3'd5;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prob_value;
    logic                  final_entry;
  } in_beat_t;

  typedef struct packed {
    logic [BIN_AW-1:0] bin_index;
    logic [SUM_W-1:0]  marginal_sum;
    logic              last_bin;
  } out_beat_t;

  typedef struct packed {
    logic [VCNT_W-1:0] var_count;
    logic [CARD_W-1:0] card_a;
    logic [CARD_W-1:0] card_b;
    logic [CARD_W-1:0] card_c;
    logic [CARD_W-1:0] card_d;
    logic [POS_W-1:0]  keep_position;
  } cfg_t;

  function automatic logic [VCNT_W-1:0] eff_vars(input cfg_t c);
    logic [VCNT_W-1:0] n;
    n = c.var_count;
    if (n == '0) n = VCNT_W'(1);
    if (n > VCNT_W'(MAX_VARS)) n = VCNT_W'(MAX_VARS);
    return n;
  endfunction

  function automatic logic [CARD_W-1:0] eff_card(input cfg_t c, input logic [POS_W-1:0] pos);
    logic [CARD_W-1:0] v;
    case (pos)
      2'd0: v = c.card_a;
      2'd1: v = c.card_b;
      2'd2: v = c.card_c;
      2'd3: v = c.card_d;
      default: v = CARD_W'(1);
    endcase
    if (v == '0) v = CARD_W'(1);
    if (v > CARD_W'(MAX_CARD)) v = CARD_W'(MAX_CARD);
    if ({1'b0, pos} >= eff_vars(c)) v = CARD_W'(1);
    return v;
  endfunction

endpackage

FILE: hw/rtl/factor_marginal_accumulate_unit.sv
// Factor marginal accumulate unit: top level with config registers,
// accumulate pipeline and bin emission sequencer.
// Depends on fma_pkg, fma_bin_ram, fma_digit_ctr.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one table entry per
//   beat in mixed-radix order, first variable fastest. Each accepted entry
//   is added, saturating, into the bin of the kept variable's digit.
//   Non-final entries are taken one per cycle: a bin read is issued in the
//   accept cycle and the sum is written back the next; back-to-back hits
//   on one bin are forwarded around the RAM.
//   An entry with final_entry set stalls the input and clears the digits.
//   After its write-back, the bins 0..kcard-1 are emitted on the output
//   channel (out_valid/out_stall/out_data), one beat per bin, last_bin on
//   the final one; each bin passes through RAM read, output load and
//   handoff, plus any receiver stall. The output beat is held while
//   out_stall is high. After the last bin is taken, all bins are cleared
//   and input resumes. Configuration (cfg_we/cfg_index/cfg_wdata) must be
//   written only when idle; the block itself does not enforce this. Reset
//   loads the default configuration, zeroes digits and marks every bin
//   empty through per-bin valid flags; no clearing sweep is needed.
module factor_marginal_accumulate_unit
  import fma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_ACC = 3'd0;
  localparam logic [2:0] ST_WB  = 3'd1;
  localparam logic [2:0] ST_RD  = 3'd2;
  localparam logic [2:0] ST_LD  = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  cfg_t                  cfg_r;
  logic [2:0]            state_r, state_nxt;
  logic [BIN_AW-1:0]     k_r;
  logic [MAX_CARD-1:0]   vld_r;

  logic                  s1_vld_r;
  logic [BIN_AW-1:0]     s1_addr_r;
  logic [VALUE_BITS-1:0] s1_val_r;

  logic                  fwd_hit_r;
  logic [SUM_W-1:0]      fwd_data_r;
  logic [BIN_AW-1:0]     rd_addr_r;

  logic                  out_valid_r;
  out_beat_t             out_data_r;

  logic                  in_acc;
  logic [DIG_W-1:0]      kept;
  logic [BIN_AW-1:0]     raddr;
  logic [SUM_W-1:0]      ram_q;
  logic [SUM_W-1:0]      entry;
  logic [SUM_W:0]        sum;
  logic [SUM_W-1:0]      wdata;
  logic [CARD_W-1:0]     kcard;
  logic                  is_last;

  assign in_stall = (state_r != ST_ACC);
  assign in_acc   = in_valid && !in_stall;
  assign kcard    = eff_card(cfg_r, cfg_r.keep_position);
  assign is_last  = (CARD_W'(k_r) + CARD_W'(1)) == kcard;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.var_count     <= VCNT_W'(1);
      cfg_r.card_a        <= CARD_W'(2);
      cfg_r.card_b        <= CARD_W'(1);
      cfg_r.card_c        <= CARD_W'(1);
      cfg_r.card_d        <= CARD_W'(1);
      cfg_r.keep_position <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VAR_COUNT:     cfg_r.var_count     <= cfg_wdata[VCNT_W-1:0];
        REG_CARD_A:        cfg_r.card_a        <= cfg_wdata[CARD_W-1:0];
        REG_CARD_B:        cfg_r.card_b        <= cfg_wdata[CARD_W-1:0];
        REG_CARD_C:        cfg_r.card_c        <= cfg_wdata[CARD_W-1:0];
        REG_CARD_D:        cfg_r.card_d        <= cfg_wdata[CARD_W-1:0];
        REG_KEEP_POSITION: cfg_r.keep_position <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  fma_digit_ctr u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (in_acc && !in_data.final_entry),
    .clr   (in_acc && in_data.final_entry),
    .kept  (kept)
  );

  assign raddr = (state_r == ST_RD) ? k_r : BIN_AW'(kept);

  // entry value as seen by the stage after the read, with write forwarding
  assign entry = fwd_hit_r ? fwd_data_r : (vld_r[rd_addr_r] ? ram_q : '0);
  assign sum   = {1'b0, entry} + (SUM_W+1)'(s1_val_r);
  assign wdata = sum[SUM_W] ? '1 : sum[SUM_W-1:0];

  fma_bin_ram u_bins (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    s1_addr_r  <= BIN_AW'(kept);
    s1_val_r   <= in_data.prob_value;
    rd_addr_r  <= raddr;
    fwd_data_r <= wdata;
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_acc;
      fwd_hit_r <= s1_vld_r && (s1_addr_r == raddr);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC:  if (in_acc && in_data.final_entry) state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = out_data_r.last_bin ? ST_ACC : ST_RD;
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      k_r         <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (s1_vld_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      case (state_r)
        ST_WB: k_r <= '0;
        ST_LD: out_valid_r <= 1'b1;
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + BIN_AW'(1);
            if (out_data_r.last_bin) begin
              vld_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LD) begin
      out_data_r.bin_index    <= k_r;
      out_data_r.marginal_sum <= entry;
      out_data_r.last_bin     <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/fma_bin_ram.sv
// Bin accumulator storage: one write port, one registered read port.
// Depends on fma_pkg.
module fma_bin_ram
  import fma_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [BIN_AW-1:0] waddr,
  input  logic [SUM_W-1:0]  wdata,
  input  logic [BIN_AW-1:0] raddr,
  output logic [SUM_W-1:0]  rdata
);

  logic [SUM_W-1:0] mem [MAX_CARD];
  logic [SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fma_digit_ctr.sv
// Mixed-radix digit counters for the table scope; yields the kept digit.
// Depends on fma_pkg.
module fma_digit_ctr
  import fma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             step,
  input  logic             clr,
  output logic [DIG_W-1:0] kept
);

  logic [DIG_W-1:0]  dig_r   [MAX_VARS];
  logic [DIG_W-1:0]  dig_nxt [MAX_VARS];
  logic [VCNT_W-1:0] nvars;

  assign nvars = eff_vars(cfg);

  always_comb begin
    logic             carry;
    logic [DIG_W:0]   inc;
    carry = 1'b1;
    for (int i = 0; i < MAX_VARS; i++) begin
      dig_nxt[i] = dig_r[i];
      inc = {1'b0, dig_r[i]} + (DIG_W+1)'(1);
      if (carry && (VCNT_W'(i) < nvars)) begin
        if (inc >= (DIG_W+1)'(eff_card(cfg, POS_W'(i)))) begin
          dig_nxt[i] = '0;
        end else begin
          dig_nxt[i] = inc[DIG_W-1:0];
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < MAX_VARS; i++) dig_r[i] <= '0;
    end else if (step) begin
      for (int i = 0; i < MAX_VARS; i++) dig_r[i] <= dig_nxt[i];
    end
  end

  assign kept = ({1'b0, cfg.keep_position} < nvars) ? dig_r[cfg.keep_position] : '0;

endmodule

FILE: hw/rtl/fma_checker.sv
// Port-level checker for the factor marginal accumulate unit, bound to the
// top level. Depends on fma_pkg and factor_marginal_accumulate_unit.
module fma_checker
  import fma_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.final_entry |=> in_stall)
    else $error("input not stalled after final entry");

  a_no_in_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while bins are emitted");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_bin |=> !out_valid && !in_stall)
    else $error("emission did not end after last bin");

endmodule

bind factor_marginal_accumulate_unit fma_checker u_fma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
